### rtl/tdu_pkg.sv
// ----------------------------------------------------------------------------
// tdu_pkg
// Shared types, codes and constants of the two-bit DNA unpacker.
// ----------------------------------------------------------------------------
package tdu_pkg;

  localparam int unsigned MaxBlocksDefault = 16;
  localparam int unsigned MaxResults       = 4;

  localparam logic [7:0] CharN       = 8'h4E;
  localparam logic [7:0] LowerOffset = 8'h20;

  typedef enum logic [1:0] {
    OP_WR_UNKNOWN = 2'd0,
    OP_WR_MASK    = 2'd1,
    OP_DECODE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_SEQ_LEN    = 2'd0,
    CFG_UNK_COUNT  = 2'd1,
    CFG_MASK_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ISS_IDLE,
    ISS_CHECK,
    ISS_RUN
  } iss_state_e;

  // one base travelling down the cell row
  typedef struct packed {
    logic        valid;
    logic [31:0] pos;
    logic [7:0]  letter;
    logic        err;
    logic        last;
    logic        unk_hit;
    logic        msk_hit;
  } tok_t;

  // table entry write broadcast to all cells
  typedef struct packed {
    logic        unk_en;
    logic        msk_en;
    logic [3:0]  slot;
    logic [31:0] first;
    logic [31:0] past;
  } tbl_wr_t;

  function automatic logic [7:0] base_letter(logic [1:0] code);
    logic [7:0] ch;
    case (code)
      2'd0:    ch = 8'h54;
      2'd1:    ch = 8'h43;
      2'd2:    ch = 8'h41;
      default: ch = 8'h47;
    endcase
    return ch;
  endfunction

endpackage

### rtl/tdu_cell.sv
// ----------------------------------------------------------------------------
// tdu_cell
// One cell of the block row: holds one unknown entry and one mask entry,
// checks the passing base against both and hands it to the next cell.
// ----------------------------------------------------------------------------
module tdu_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdu_pkg::tbl_wr_t wr_i,
  input  logic [4:0]       unk_count_i,
  input  logic [4:0]       msk_count_i,
  input  logic             adv_i,
  input  tdu_pkg::tok_t    tok_i,
  output tdu_pkg::tok_t    tok_o
);
  import tdu_pkg::*;

  logic [31:0] unk_start_q, unk_end_q, msk_start_q, msk_end_q;
  logic        slot_match, unk_en, msk_en, unk_hit, msk_hit;
  tok_t        tok_d, tok_q;

  assign slot_match = (32'(wr_i.slot) == 32'(CellIdx));
  assign unk_en     = (32'(unk_count_i) > 32'(CellIdx));
  assign msk_en     = (32'(msk_count_i) > 32'(CellIdx));

  assign unk_hit = unk_en && (tok_i.pos >= unk_start_q) && (tok_i.pos < unk_end_q);
  assign msk_hit = msk_en && (tok_i.pos >= msk_start_q) && (tok_i.pos < msk_end_q);

  always_comb begin
    tok_d         = tok_i;
    tok_d.unk_hit = tok_i.unk_hit | unk_hit;
    tok_d.msk_hit = tok_i.msk_hit | msk_hit;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.unk_en && slot_match) begin
      unk_start_q <= wr_i.first;
      unk_end_q   <= wr_i.past;
    end
    if (wr_i.msk_en && slot_match) begin
      msk_start_q <= wr_i.first;
      msk_end_q   <= wr_i.past;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/tdu_issue.sv
// ----------------------------------------------------------------------------
// tdu_issue
// Takes one decode item, checks the query window and sequence length,
// then feeds the selected bases (or one error item) into the cell row.
// ----------------------------------------------------------------------------
module tdu_issue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [7:0]    packed_byte_i,
  input  logic [29:0]   byte_index_i,
  input  logic [31:0]   query_start_i,
  input  logic [31:0]   query_end_i,
  input  logic [31:0]   seq_len_i,
  input  logic          adv_i,
  output logic          idle_o,
  output tdu_pkg::tok_t tok_o
);
  import tdu_pkg::*;

  iss_state_e  state_q, state_d;
  logic [7:0]  byte_q;
  logic [29:0] bidx_q;
  logic [31:0] qs_q, qe_q;
  logic [3:0]  mask_q, mask_d, win;
  logic        err_q, err_d, bad;
  logic [1:0]  k_sel;
  logic [3:0]  k_hot;
  logic [1:0]  code;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win[k] = ({bidx_q, 2'(k)} >= qs_q) && ({bidx_q, 2'(k)} < qe_q);
    end
  end

  assign bad = (qs_q >= seq_len_i) || (qe_q > seq_len_i);

  always_comb begin
    if (mask_q[0]) begin
      k_sel = 2'd0;
    end else if (mask_q[1]) begin
      k_sel = 2'd1;
    end else if (mask_q[2]) begin
      k_sel = 2'd2;
    end else begin
      k_sel = 2'd3;
    end
  end

  assign k_hot = 4'b0001 << k_sel;
  assign code  = 2'(byte_q >> {~k_sel, 1'b0});

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    err_d   = err_q;
    tok_o   = '0;
    case (state_q)
      ISS_IDLE: begin
        if (start_i) begin
          state_d = ISS_CHECK;
        end
      end
      ISS_CHECK: begin
        err_d  = bad;
        mask_d = bad ? 4'b0000 : win;
        if (bad || (win != 4'b0000)) begin
          state_d = ISS_RUN;
        end else begin
          state_d = ISS_IDLE;
        end
      end
      ISS_RUN: begin
        tok_o.valid = 1'b1;
        if (err_q) begin
          tok_o.err  = 1'b1;
          tok_o.last = 1'b1;
        end else begin
          tok_o.pos    = {bidx_q, k_sel};
          tok_o.letter = base_letter(code);
          tok_o.last   = ((mask_q & ~k_hot) == 4'b0000);
        end
        if (adv_i) begin
          mask_d = mask_q & ~k_hot;
          err_d  = 1'b0;
          if (tok_o.last) begin
            state_d = ISS_IDLE;
          end
        end
      end
      default: state_d = ISS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ISS_IDLE;
      mask_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ISS_IDLE)) begin
      byte_q <= packed_byte_i;
      bidx_q <= byte_index_i;
      qs_q   <= query_start_i;
      qe_q   <= query_end_i;
    end
  end

  assign idle_o = (state_q == ISS_IDLE);

  property p_run_has_work;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ISS_RUN) |-> (err_q || (mask_q != 4'b0000));
  endproperty
  a_run_has_work: assert property (p_run_has_work)
    else $error("issuer running with nothing to send");

endmodule

### rtl/twobit_dna_unpack_masked.sv
// ----------------------------------------------------------------------------
// twobit_dna_unpack_masked
// Unpacks 2-bit DNA bytes to ASCII, marking unknown blocks as N and
// lower-casing masked blocks, through a row of block-table cells.
// ----------------------------------------------------------------------------
// a decode item passes the issuer's check and run states, each cell register of the row and the output register
// results leave one per cycle while the receiver is ready; the next item is taken once the
//   cell row drains and the issuer is idle; when no base falls in the window, the issuer
//   goes back to idle without sending anything
// table writes and ignored ops are taken without entering the cell row
// reset clears control and config state; table contents and output data stay undefined
module twobit_dna_unpack_masked #(
  parameter int unsigned MaxBlocks = tdu_pkg::MaxBlocksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] block_begin_i,
  input  logic [31:0] block_finish_i,
  input  logic [7:0]  packed_byte_i,
  input  logic [29:0] byte_index_i,
  input  logic [31:0] query_start_i,
  input  logic [31:0] query_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  base_char_o,
  output logic [31:0] base_position_o,
  output logic        range_error_o,
  output logic        last_o
);
  import tdu_pkg::*;

  logic [31:0] seq_len_q;
  logic [4:0]  unk_count_q, msk_count_q;
  logic        in_acc, adv, iss_idle, start;
  logic [2:0]  inflight_q, inflight_d;
  tbl_wr_t     wr;
  tok_t        row [MaxBlocks+1];
  tok_t        tail;
  logic        out_valid_q;
  logic [7:0]  char_q, char_d;
  logic [31:0] pos_q;
  logic        err_q, last_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q   <= '0;
      unk_count_q <= '0;
      msk_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEQ_LEN:    seq_len_q   <= cfg_data_i;
        CFG_UNK_COUNT:  unk_count_q <= cfg_data_i[4:0];
        CFG_MASK_COUNT: msk_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_ready_o = iss_idle && (inflight_q == 3'd0);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && (op_i == OP_DECODE);
  assign adv        = !out_valid_q || out_ready_i;

  assign wr.unk_en = in_acc && (op_i == OP_WR_UNKNOWN);
  assign wr.msk_en = in_acc && (op_i == OP_WR_MASK);
  assign wr.slot   = entry_index_i;
  assign wr.first  = block_begin_i;
  assign wr.past   = block_finish_i;

  tdu_issue u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .packed_byte_i(packed_byte_i),
    .byte_index_i (byte_index_i),
    .query_start_i(query_start_i),
    .query_end_i  (query_end_i),
    .seq_len_i    (seq_len_q),
    .adv_i        (adv),
    .idle_o       (iss_idle),
    .tok_o        (row[0])
  );

  for (genvar i = 0; i < MaxBlocks; i++) begin : g_cell
    tdu_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr),
      .unk_count_i(unk_count_q),
      .msk_count_i(msk_count_q),
      .adv_i      (adv),
      .tok_i      (row[i]),
      .tok_o      (row[i+1])
    );
  end

  assign tail = row[MaxBlocks];

  // items inside the row
  always_comb begin
    inflight_d = inflight_q;
    if (adv) begin
      inflight_d = inflight_q + 3'(row[0].valid) - 3'(tail.valid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // output register
  always_comb begin
    if (tail.err) begin
      char_d = '0;
    end else begin
      char_d = (tail.unk_hit ? CharN : tail.letter) + (tail.msk_hit ? LowerOffset : 8'h00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_q <= char_d;
      pos_q  <= tail.pos;
      err_q  <= tail.err;
      last_q <= tail.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign base_char_o     = char_q;
  assign base_position_o = pos_q;
  assign range_error_o   = err_q;
  assign last_o          = last_q;

  property p_ready_drained;
    @(posedge clk_i) disable iff (!rst_ni)
      in_ready_o |-> (inflight_q == 3'd0);
  endproperty
  a_ready_drained: assert property (p_ready_drained)
    else $error("item taken while row busy");

  property p_inflight_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      32'(inflight_q) <= MaxResults;
  endproperty
  a_inflight_bound: assert property (p_inflight_bound)
    else $error("too many items in row");

  property p_error_item;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && range_error_o) |->
        (last_o && (base_char_o == 8'h00) && (base_position_o == 32'h0));
  endproperty
  a_error_item: assert property (p_error_item)
    else $error("malformed error item");

endmodule

### test/twobit_dna_unpack_masked_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twobit_dna_unpack_masked_test
// Checks the two-bit DNA unpacker against an in-bench prediction of the
// letters, positions, range errors and last flags of every decoded byte,
// with directed block tables, config extremes and paced random traffic.
// ----------------------------------------------------------------------------
module twobit_dna_unpack_masked_test;
  import tdu_pkg::*;

  localparam int unsigned MaxBlocks   = MaxBlocksDefault;
  localparam int unsigned DrainCycles = 2 * (MaxBlocks + 6);
  localparam int unsigned CycleLimit  = 200000;
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int          TblUnknown  = 0;
  localparam int          TblMask     = 1;
  localparam logic [31:0] BaseLetters = {8'h47, 8'h41, 8'h43, 8'h54};

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] blk_first;
    logic [31:0] blk_past;
    logic [7:0]  bits;
    logic [29:0] byte_idx;
    logic [31:0] win_lo;
    logic [31:0] win_hi;
  } dna_item_t;

  typedef struct {
    logic [7:0]  base_char;
    logic [31:0] base_position;
    logic        range_error;
    logic        last;
  } base_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = CFG_SEQ_LEN;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i           = OP_DECODE;
  logic [3:0]  entry_index_i  = '0;
  logic [31:0] block_begin_i  = '0;
  logic [31:0] block_finish_i = '0;
  logic [7:0]  packed_byte_i  = '0;
  logic [29:0] byte_index_i   = '0;
  logic [31:0] query_start_i  = '0;
  logic [31:0] query_end_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  base_char_o;
  logic [31:0] base_position_o;
  logic        range_error_o;
  logic        last_o;

  // predicted block state and config
  logic [31:0]  seq_len = '0;
  logic [4:0]   blk_count [2];
  logic [31:0]  blk_first_tbl [2][MaxBlocks];
  logic [31:0]  blk_past_tbl [2][MaxBlocks];
  base_result_t expected_bases [$];
  int           mismatch_count     = 0;
  int           sender_idle_pct    = 0;
  int           receiver_stall_pct = 0;

  twobit_dna_unpack_masked i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .block_begin_i  (block_begin_i),
    .block_finish_i (block_finish_i),
    .packed_byte_i  (packed_byte_i),
    .byte_index_i   (byte_index_i),
    .query_start_i  (query_start_i),
    .query_end_i    (query_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .base_char_o    (base_char_o),
    .base_position_o(base_position_o),
    .range_error_o  (range_error_o),
    .last_o         (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit in_block(int tbl, logic [31:0] pos);
    int n;
    bit hit;
    n = (blk_count[tbl] > MaxBlocks) ? MaxBlocks : blk_count[tbl];
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (pos >= blk_first_tbl[tbl][i] && pos < blk_past_tbl[tbl][i]) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic predict_bases(dna_item_t it);
    base_result_t batch [$];
    base_result_t r;
    logic [31:0]  pos;
    logic [7:0]   ch;
    logic [1:0]   code;
    int           tbl;
    case (it.op)
      OP_WR_UNKNOWN, OP_WR_MASK: begin
        tbl = (it.op == OP_WR_MASK) ? TblMask : TblUnknown;
        blk_first_tbl[tbl][it.slot] = it.blk_first;
        blk_past_tbl[tbl][it.slot]  = it.blk_past;
      end
      OP_DECODE: begin
        if (it.win_lo >= seq_len || it.win_hi > seq_len) begin
          r = '{8'h00, 32'd0, 1'b1, 1'b1};
          expected_bases.insert(expected_bases.size(), r);
        end else begin
          for (int k = 0; k < 4; k++) begin
            pos = {it.byte_idx, 2'b00} + k;
            if (pos >= it.win_lo && pos < it.win_hi) begin
              code = it.bits[6 - 2 * k +: 2];
              ch = BaseLetters[8 * code +: 8];
              if (in_block(TblUnknown, pos)) ch = CharN;
              if (in_block(TblMask, pos)) ch = ch + LowerOffset;
              r = '{ch, pos, 1'b0, 1'b0};
              batch.insert(batch.size(), r);
            end
          end
          if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
          foreach (batch[i]) expected_bases.insert(expected_bases.size(), batch[i]);
        end
      end
      default: ;
    endcase
  endtask

  function automatic dna_item_t rand_item();
    dna_item_t it;
    it.op        = 2'($urandom_range(0, 3));
    it.slot      = 4'($urandom_range(0, 15));
    it.blk_first = $urandom;
    it.blk_past  = $urandom;
    it.bits      = 8'($urandom_range(0, 255));
    it.byte_idx  = 30'($urandom);
    it.win_lo    = $urandom;
    it.win_hi    = $urandom;
    return it;
  endfunction

  // block entry near the working region of a traffic phase
  function automatic dna_item_t region_block(logic [1:0] op, logic [31:0] region);
    dna_item_t it;
    it = rand_item();
    it.op = op;
    it.blk_first = region + $urandom_range(0, 127);
    if ($urandom_range(0, 7) == 0) it.blk_past = it.blk_first - $urandom_range(0, 3);
    else it.blk_past = it.blk_first + $urandom_range(1, 12);
    return it;
  endfunction

  task automatic send_item(dna_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i           <= it.op;
    entry_index_i  <= it.slot;
    block_begin_i  <= it.blk_first;
    block_finish_i <= it.blk_past;
    packed_byte_i  <= it.bits;
    byte_index_i   <= it.byte_idx;
    query_start_i  <= it.win_lo;
    query_end_i    <= it.win_hi;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_bases(it);
  endtask

  task automatic send_table(logic [1:0] op, logic [3:0] slot, logic [31:0] first,
                            logic [31:0] past);
    dna_item_t it;
    it = rand_item();
    it.op        = op;
    it.slot      = slot;
    it.blk_first = first;
    it.blk_past  = past;
    send_item(it);
  endtask

  task automatic send_decode(logic [7:0] bits, logic [29:0] byte_idx, logic [31:0] lo,
                             logic [31:0] hi);
    dna_item_t it;
    it = rand_item();
    it.op       = OP_DECODE;
    it.bits     = bits;
    it.byte_idx = byte_idx;
    it.win_lo   = lo;
    it.win_hi   = hi;
    send_item(it);
  endtask

  // drop valid, wait for every predicted result, then let the cell row drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bases.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SEQ_LEN:    seq_len = data;
      CFG_UNK_COUNT:  blk_count[TblUnknown] = data[4:0];
      CFG_MASK_COUNT: blk_count[TblMask] = data[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // zero length after reset, so any query is out of range
  task automatic test_reset_state();
    send_decode(8'h1B, 30'd0, 32'd0, 32'd4);
  endtask

  task automatic test_directed_decode();
    dna_item_t it;
    send_table(OP_WR_UNKNOWN, 4'd0, 32'd8, 32'd12);
    send_table(OP_WR_UNKNOWN, 4'd1, 32'd20, 32'd20);
    send_table(OP_WR_UNKNOWN, 4'd2, 32'd30, 32'd25);
    send_table(OP_WR_UNKNOWN, 4'd3, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_table(OP_WR_MASK, 4'd0, 32'd10, 32'd14);
    send_table(OP_WR_MASK, 4'd1, 32'd0, 32'd0);
    send_table(OP_WR_MASK, 4'd2, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send_table(OP_WR_MASK, 4'd3, 32'd40, 32'd44);
    send_table(OP_WR_MASK, 4'd15, 32'hFFFF_FFFF, 32'd0);
    it = rand_item();
    it.op = OpUnused;
    send_item(it);
    cfg_write(CFG_SEQ_LEN, 32'hFFFF_FFFF);
    cfg_write(CFG_UNK_COUNT, 32'd4);
    cfg_write(CFG_MASK_COUNT, 32'd4);
    send_decode(8'h1B, 30'd0, 32'd0, 32'hFFFF_FFFF);
    send_decode(8'hE4, 30'd2, 32'd0, 32'd64);
    send_decode(8'hFF, 30'd3, 32'd0, 32'd64);
    send_decode(8'h00, 30'h3FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_decode(8'h55, 30'd5, 32'd21, 32'd23);
    // empty window, reversed window, window missing the byte
    send_decode(8'hAA, 30'd6, 32'd30, 32'd30);
    send_decode(8'hAA, 30'd6, 32'd30, 32'd10);
    send_decode(8'h6C, 30'd7, 32'd0, 32'd20);
    send_decode(8'h93, 30'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    cfg_write(CFG_SEQ_LEN, 32'd100);
    send_decode(8'h93, 30'd3, 32'd10, 32'd101);
    send_decode(8'h93, 30'd24, 32'd96, 32'd100);
    cfg_write(CFG_UNK_COUNT, 32'd0);
    cfg_write(CFG_MASK_COUNT, 32'd0);
    send_decode(8'hE4, 30'd2, 32'd0, 32'd100);
  endtask

  // counts above the table size clamp to the full table
  task automatic test_count_overflow();
    logic [29:0] bi;
    logic [31:0] lo;
    for (int s = 0; s < MaxBlocks; s++) begin
      send_table(OP_WR_UNKNOWN, 4'(s), $urandom, $urandom);
      send_table(OP_WR_MASK, 4'(s), $urandom, $urandom);
    end
    cfg_write(CFG_SEQ_LEN, 32'hFFFF_FFFF);
    cfg_write(CFG_UNK_COUNT, 32'd31);
    cfg_write(CFG_MASK_COUNT, 32'd17);
    repeat (6) begin
      bi = 30'($urandom);
      lo = {bi, 2'b00};
      send_decode(8'($urandom_range(0, 255)), bi, lo, lo + $urandom_range(1, 3));
    end
    cfg_write(CFG_UNK_COUNT, 32'd16);
    cfg_write(CFG_MASK_COUNT, 32'd16);
    send_decode(8'h1B, 30'd2, 32'd0, 32'd16);
    cfg_write(CFG_SEQ_LEN, 32'd0);
    send_decode(8'hC6, 30'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items,
                                     bit top_region, bit pause_midway);
    logic [31:0] region;
    logic [31:0] p0;
    logic [31:0] off;
    logic [32:0] wide;
    logic [29:0] bi;
    dna_item_t   it;
    int          pick;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    region = top_region ? 32'hFFFF_FF80 : ($urandom & 32'hFFFF_F000);
    wide = {1'b0, region} + $urandom_range(140, 220);
    cfg_write(CFG_SEQ_LEN, (top_region || wide[32]) ? 32'hFFFF_FFFF : wide[31:0]);
    cfg_write(CFG_UNK_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(1, 16));
    cfg_write(CFG_MASK_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                          : $urandom_range(1, 16));
    for (int j = 0; j < 16; j++) begin
      send_item(region_block((j % 2) ? OP_WR_MASK : OP_WR_UNKNOWN, region));
    end
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_idle();
      pick = $urandom_range(0, 99);
      it = rand_item();
      if (pick < 12) begin
        it = region_block($urandom_range(0, 1) ? OP_WR_MASK : OP_WR_UNKNOWN, region);
      end else if (pick >= 17) begin
        it.op = OP_DECODE;
        bi = 30'(region[31:2] + $urandom_range(0, 31));
        it.byte_idx = bi;
        p0 = {bi, 2'b00};
        off = $urandom_range(0, 3);
        it.win_lo = ($urandom_range(0, 3) == 0) ? region : ((p0 >= off) ? p0 - off : 32'd0);
        it.win_hi = ($urandom_range(0, 4) == 0) ? seq_len : p0 + $urandom_range(0, 6);
        if (pick < 25) begin
          // out of range query
          if (seq_len == 32'hFFFF_FFFF || $urandom_range(0, 1)) it.win_lo = seq_len;
          else it.win_hi = seq_len + 1 + $urandom_range(0, 3);
        end
      end
      send_item(it);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : check_bases
    base_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bases.size() == 0) begin
        $error("unexpected result: base_char %h, base_position %h", base_char_o,
               base_position_o);
        mismatch_count++;
      end else begin
        want = expected_bases.pop_front();
        if (base_char_o !== want.base_char) begin
          $error("base_char: expected %h, got %h", want.base_char, base_char_o);
          mismatch_count++;
        end
        if (base_position_o !== want.base_position) begin
          $error("base_position: expected %h, got %h", want.base_position,
                 base_position_o);
          mismatch_count++;
        end
        if (range_error_o !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, range_error_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    blk_count[TblUnknown] = '0;
    blk_count[TblMask]    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_decode();
    test_count_overflow();
    test_random_traffic(0, 0, 15, 1'b0, 1'b0);
    test_random_traffic(57, 0, 15, 1'b1, 1'b0);
    test_random_traffic(0, 57, 15, 1'b0, 1'b1);
    test_random_traffic(11, 11, 15, 1'b0, 1'b0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
